@@ sv/cmmsf_pkg.sv @@
// Shared kinds, constants and order-key helpers for the column min/max fold.
`default_nettype none
package cmmsf_pkg;

    localparam int MAX_VALUE_BYTES = 8;
    localparam int VAL_W = 8 * MAX_VALUE_BYTES;
    localparam int LEN_W = 4;
    localparam int SUM_W = 56;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_I32   = 3'd1,
        K_I64   = 3'd2,
        K_F32   = 3'd3,
        K_F64   = 3'd4,
        K_BOOL  = 3'd5,
        K_BYTES = 3'd6,
        K_RSVD  = 3'd7
    } t_kind;

    typedef enum logic {
        OP_FOLD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    function automatic t_kind kind_now(input logic [2:0] raw);
        t_kind k;
        k = t_kind'(raw);
        if (k == K_RSVD) begin
            k = K_NONE;
        end
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [VAL_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_VALUE_BYTES; i++) begin
            if (LEN_W'(i) < len) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] kind_width(input t_kind k);
        logic [3:0] w;
        unique case (k)
            K_I32, K_F32: w = 4'd4;
            K_I64, K_F64: w = 4'd8;
            K_BOOL:       w = 4'd1;
            default:      w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] order_key(input t_kind k, input logic [63:0] v);
        logic [63:0] key;
        unique case (k)
            K_I32: key = {32'd0, v[31] ^ 1'b1, v[30:0]};
            K_I64: key = {v[63] ^ 1'b1, v[62:0]};
            K_F32: key = v[31] ? {32'd0, ~v[31:0]} : {32'd0, 1'b1, v[30:0]};
            K_F64: key = v[63] ? ~v : {1'b1, v[62:0]};
            default: key = {56'd0, v[7:0]};
        endcase
        return key;
    endfunction

endpackage
`default_nettype wire

@@ sv/column_min_max_stats_fold.sv @@
// Top level of the column min/max statistics fold.
//
//  channel  dir  handshake               payload
//  in       in   i_in_valid/o_in_stall   operation .. column_id
//  out      out  o_out_valid/i_out_stall entry_valid .. upper_value
//  cfg      in   i_cfg_we                i_cfg_wdata (value_kind)
//
// One request per cycle while o_in_stall is low; a fold updates the running state at acceptance.
// An emit loads the result register and is seen in the cycle after acceptance.
// Input stalls only while a held result is itself stalled.
// Synchronous active-low reset clears the fold and sets the kind to none.
`default_nettype none
module column_min_max_stats_fold
    import cmmsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [48:0]       i_null_count,
    input  logic [47:0]       i_num_values,
    input  logic [7:0]        i_min_len,
    input  logic [63:0]       i_min_value,
    input  logic [7:0]        i_max_len,
    input  logic [63:0]       i_max_value,
    input  logic              i_min_is_exact,
    input  logic              i_max_is_exact,
    input  logic [30:0]       i_column_id,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_entry_valid,
    output logic [30:0]       o_entry_id,
    output logic [55:0]       o_null_total,
    output logic              o_has_lower,
    output logic [3:0]        o_lower_len,
    output logic [63:0]       o_lower_value,
    output logic              o_has_upper,
    output logic [3:0]        o_upper_len,
    output logic [63:0]       o_upper_value
);

    logic [2:0]        r_kind;
    logic [SUM_W-1:0]  r_null_sum;
    logic              r_sum_known;
    logic              r_lower_ok;
    logic              r_upper_ok;
    logic              r_seen_any;
    logic [LEN_W-1:0]  r_low_len;
    logic [LEN_W-1:0]  r_high_len;
    logic [VAL_W-1:0]  r_low_bytes;
    logic [VAL_W-1:0]  r_high_bytes;
    logic              r_out_valid;

    t_kind             kind;
    logic              accept;
    logic              nc_neg;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  n_null_sum;
    logic              all_null;
    logic              lo_ok, lo_take, hi_ok, hi_take;
    logic [LEN_W-1:0]  lo_len, hi_len;
    logic [VAL_W-1:0]  lo_val, hi_val;
    logic              has_bounds;
    logic              clear_ok;

    assign kind       = kind_now(r_kind);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign nc_neg     = i_null_count[48];
    assign sum_wide   = {1'b0, r_null_sum} + {9'd0, i_null_count[47:0]};
    assign n_null_sum = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign all_null   = !nc_neg && (i_null_count[47:0] == i_num_values);
    assign has_bounds = kind != K_NONE && r_seen_any;
    assign clear_ok   = kind_now(i_cfg_wdata) != K_NONE;

    cmmsf_side u_lower (
        .i_kind(kind), .i_want_greater(1'b0), .i_seen(r_seen_any), .i_ok(r_lower_ok),
        .i_len(i_min_len), .i_value(i_min_value), .i_exact(i_min_is_exact),
        .i_cur_len(r_low_len), .i_cur_value(r_low_bytes),
        .o_ok(lo_ok), .o_take(lo_take), .o_len(lo_len), .o_value(lo_val)
    );

    cmmsf_side u_upper (
        .i_kind(kind), .i_want_greater(1'b1), .i_seen(r_seen_any), .i_ok(r_upper_ok),
        .i_len(i_max_len), .i_value(i_max_value), .i_exact(i_max_is_exact),
        .i_cur_len(r_high_len), .i_cur_value(r_high_bytes),
        .o_ok(hi_ok), .o_take(hi_take), .o_len(hi_len), .o_value(hi_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= K_NONE;
            r_null_sum    <= '0;
            r_sum_known   <= 1'b1;
            r_lower_ok    <= 1'b0;
            r_upper_ok    <= 1'b0;
            r_seen_any    <= 1'b0;
            r_low_len     <= '0;
            r_high_len    <= '0;
            r_low_bytes   <= '0;
            r_high_bytes  <= '0;
        end else if (i_cfg_we) begin
            r_kind        <= i_cfg_wdata;
            r_null_sum    <= '0;
            r_sum_known   <= 1'b1;
            r_lower_ok    <= clear_ok;
            r_upper_ok    <= clear_ok;
            r_seen_any    <= 1'b0;
            r_low_len     <= '0;
            r_high_len    <= '0;
            r_low_bytes   <= '0;
            r_high_bytes  <= '0;
        end else if (accept) begin
            if (t_op'(i_operation) == OP_EMIT) begin
                r_null_sum    <= '0;
                r_sum_known   <= 1'b1;
                r_lower_ok    <= kind != K_NONE;
                r_upper_ok    <= kind != K_NONE;
                r_seen_any    <= 1'b0;
                r_low_len     <= '0;
                r_high_len    <= '0;
                r_low_bytes   <= '0;
                r_high_bytes  <= '0;
            end else begin
                if (nc_neg) begin
                    r_sum_known <= 1'b0;
                end else begin
                    r_null_sum <= n_null_sum;
                end
                if (!all_null) begin
                    r_lower_ok <= lo_ok;
                    r_upper_ok <= hi_ok;
                    r_seen_any <= 1'b1;
                    if (lo_take) begin
                        r_low_len   <= lo_len;
                        r_low_bytes <= lo_val;
                    end
                    if (hi_take) begin
                        r_high_len   <= hi_len;
                        r_high_bytes <= hi_val;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && t_op'(i_operation) == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_operation) == OP_EMIT) begin
            o_entry_valid <= r_sum_known;
            o_entry_id    <= i_column_id;
            o_null_total  <= r_null_sum;
            o_has_lower   <= has_bounds && r_lower_ok;
            o_lower_len   <= (has_bounds && r_lower_ok) ? r_low_len : '0;
            o_lower_value <= (has_bounds && r_lower_ok) ? r_low_bytes : '0;
            o_has_upper   <= has_bounds && r_upper_ok;
            o_upper_len   <= (has_bounds && r_upper_ok) ? r_high_len : '0;
            o_upper_value <= (has_bounds && r_upper_ok) ? r_high_bytes : '0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ sv/cmmsf_side.sv @@
// One bound side: usability check and running compare against the held bound.
`default_nettype none
module cmmsf_side
    import cmmsf_pkg::*;
(
    input  t_kind             i_kind,
    input  logic              i_want_greater,
    input  logic              i_seen,
    input  logic              i_ok,
    input  logic [7:0]        i_len,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_exact,
    input  logic [LEN_W-1:0]  i_cur_len,
    input  logic [VAL_W-1:0]  i_cur_value,
    output logic              o_ok,
    output logic              o_take,
    output logic [LEN_W-1:0]  o_len,
    output logic [VAL_W-1:0]  o_value
);

    logic              usable;
    logic [LEN_W-1:0]  n_len;
    logic [VAL_W-1:0]  v;
    logic [63:0]       ka;
    logic [63:0]       kb;
    logic [LEN_W-1:0]  nmin;
    logic              lt;
    logic              gt;
    logic              found;

    assign n_len = i_len[LEN_W-1:0];
    assign v     = i_value & len_mask(n_len);

    always_comb begin
        usable = 1'b1;
        if (i_len == 8'd0 || i_len > 8'(MAX_VALUE_BYTES)) begin
            usable = 1'b0;
        end else if (i_kind == K_BYTES) begin
            usable = i_exact;
        end else if (i_len != {4'd0, kind_width(i_kind)}) begin
            usable = 1'b0;
        end else if (i_kind == K_F32) begin
            usable = !(&i_value[30:23] && |i_value[22:0]);
        end else if (i_kind == K_F64) begin
            usable = !(&i_value[62:52] && |i_value[51:0]);
        end
    end

    always_comb begin
        ka    = order_key(i_kind, v);
        kb    = order_key(i_kind, i_cur_value);
        nmin  = (n_len < i_cur_len) ? n_len : i_cur_len;
        lt    = 1'b0;
        gt    = 1'b0;
        found = 1'b0;
        if (i_kind == K_BYTES) begin
            for (int i = 0; i < MAX_VALUE_BYTES; i++) begin
                if (!found && LEN_W'(i) < nmin && v[8*i +: 8] != i_cur_value[8*i +: 8]) begin
                    found = 1'b1;
                    lt    = v[8*i +: 8] < i_cur_value[8*i +: 8];
                    gt    = v[8*i +: 8] > i_cur_value[8*i +: 8];
                end
            end
            if (!found) begin
                lt = n_len < i_cur_len;
                gt = n_len > i_cur_len;
            end
        end else begin
            lt = ka < kb;
            gt = ka > kb;
        end
    end

    assign o_ok    = i_ok && usable;
    assign o_take  = o_ok && (!i_seen || (i_want_greater ? gt : lt));
    assign o_len   = n_len;
    assign o_value = v;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the column min/max statistics fold, with a built-in predictor.
`default_nettype none
module tb_top;
    import cmmsf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        op;
        logic [48:0] nc;
        logic [47:0] nv;
        logic [7:0]  minl;
        logic [63:0] minv;
        logic [7:0]  maxl;
        logic [63:0] maxv;
        logic        mine;
        logic        maxe;
        logic [30:0] id;
    } t_chunk;

    typedef struct packed {
        logic        ev;
        logic [30:0] id;
        logic [55:0] nt;
        logic        hl;
        logic [3:0]  ll;
        logic [63:0] lv;
        logic        hu;
        logic [3:0]  ul;
        logic [63:0] uv;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [48:0] i_null_count;
    logic [47:0] i_num_values;
    logic [7:0]  i_min_len;
    logic [63:0] i_min_value;
    logic [7:0]  i_max_len;
    logic [63:0] i_max_value;
    logic        i_min_is_exact;
    logic        i_max_is_exact;
    logic [30:0] i_column_id;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_entry_valid;
    logic [30:0] o_entry_id;
    logic [55:0] o_null_total;
    logic        o_has_lower;
    logic [3:0]  o_lower_len;
    logic [63:0] o_lower_value;
    logic        o_has_upper;
    logic [3:0]  o_upper_len;
    logic [63:0] o_upper_value;

    column_min_max_stats_fold u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [2:0]  kind_raw;
    logic [55:0] null_sum;
    logic        sum_known, lower_ok, upper_ok, seen_any;
    logic [3:0]  low_len, high_len;
    logic [63:0] low_bytes, high_bytes;

    t_entry pending_entries[$];
    int     mismatches = 0;
    int     folds_sent = 0;
    int     emits_sent = 0;
    int     entries_checked = 0;
    int     rx_hold = 0;
    bit     rx_quiet = 0;
    bit     tx_quiet = 0;

    function automatic t_kind eff_kind();
        return (kind_raw == 3'd7) ? K_NONE : t_kind'(kind_raw);
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) if (i < len) m[8*i +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic logic [3:0] width_of(input t_kind k);
        case (k)
            K_I32, K_F32: return 4'd4;
            K_I64, K_F64: return 4'd8;
            K_BOOL:       return 4'd1;
            default:      return 4'd0;
        endcase
    endfunction

    function automatic bit is_nan(input t_kind k, input logic [63:0] v);
        if (k == K_F32) return v[30:23] == 8'hFF && v[22:0] != 0;
        if (k == K_F64) return v[62:52] == 11'h7FF && v[51:0] != 0;
        return 0;
    endfunction

    function automatic bit usable(input t_kind k, input logic [7:0] len,
                                  input logic [63:0] v, input logic exact);
        if (k == K_NONE || len == 0 || len > 8) return 0;
        if (k == K_BYTES) return exact;
        if (len != {4'd0, width_of(k)}) return 0;
        return !is_nan(k, v);
    endfunction

    function automatic logic [63:0] rank(input t_kind k, input logic [63:0] v);
        case (k)
            K_I32: return {32'd0, ~v[31], v[30:0]};
            K_I64: return {~v[63], v[62:0]};
            K_F32: return v[31] ? {32'd0, ~v[31:0]} : {32'd0, 1'b1, v[30:0]};
            K_F64: return v[63] ? ~v : {1'b1, v[62:0]};
            default: return {56'd0, v[7:0]};
        endcase
    endfunction

    // -1, 0, 1 for a below, equal, above b
    function automatic int order(input t_kind k, input logic [63:0] a, input logic [3:0] al,
                                 input logic [63:0] b, input logic [3:0] bl);
        logic [63:0] ra, rb;
        if (k == K_BYTES) begin
            for (int i = 0; i < 8; i++) begin
                if (i >= al || i >= bl) break;
                if (a[8*i +: 8] != b[8*i +: 8]) return (a[8*i +: 8] < b[8*i +: 8]) ? -1 : 1;
            end
            return (al > bl) ? 1 : (al < bl) ? -1 : 0;
        end
        ra = rank(k, a);
        rb = rank(k, b);
        return (ra > rb) ? 1 : (ra < rb) ? -1 : 0;
    endfunction

    function automatic void clear_fold();
        null_sum    = '0;
        sum_known   = 1;
        lower_ok    = eff_kind() != K_NONE;
        upper_ok    = eff_kind() != K_NONE;
        seen_any    = 0;
        low_len     = '0;
        high_len    = '0;
        low_bytes   = '0;
        high_bytes  = '0;
    endfunction

    function automatic void apply_chunk(input t_chunk c);
        t_kind       k;
        t_entry      e;
        logic [56:0] acc;
        logic [63:0] v;
        k = eff_kind();
        if (c.op == OP_EMIT) begin
            e = '0;
            e.ev = sum_known;
            e.id = c.id;
            e.nt = null_sum;
            if (k != K_NONE && seen_any) begin
                if (lower_ok) begin
                    e.hl = 1; e.ll = low_len; e.lv = low_bytes & byte_mask(low_len);
                end
                if (upper_ok) begin
                    e.hu = 1; e.ul = high_len; e.uv = high_bytes & byte_mask(high_len);
                end
            end
            pending_entries.push_back(e);
            clear_fold();
            return;
        end
        if (c.nc[48]) begin
            sum_known = 0;
        end else begin
            acc = {1'b0, null_sum} + {9'd0, c.nc[47:0]};
            null_sum = (acc > 57'h0FF_FFFF_FFFF_FFFF) ? 56'hFF_FFFF_FFFF_FFFF : acc[55:0];
            if (c.nc[47:0] == c.nv) return;
        end
        if (!usable(k, c.minl, c.minv, c.mine)) lower_ok = 0;
        if (!usable(k, c.maxl, c.maxv, c.maxe)) upper_ok = 0;
        if (lower_ok) begin
            v = c.minv & byte_mask(c.minl[3:0]);
            if (!seen_any || order(k, v, c.minl[3:0], low_bytes, low_len) < 0) begin
                low_bytes = v; low_len = c.minl[3:0];
            end
        end
        if (upper_ok) begin
            v = c.maxv & byte_mask(c.maxl[3:0]);
            if (!seen_any || order(k, v, c.maxl[3:0], high_bytes, high_len) > 0) begin
                high_bytes = v; high_len = c.maxl[3:0];
            end
        end
        seen_any = 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_chunk(input t_chunk c);
        int gap;
        i_in_valid     <= 1'b1;
        i_operation    <= c.op;
        i_null_count   <= c.nc;
        i_num_values   <= c.nv;
        i_min_len      <= c.minl;
        i_min_value    <= c.minv;
        i_max_len      <= c.maxl;
        i_max_value    <= c.maxv;
        i_min_is_exact <= c.mine;
        i_max_is_exact <= c.maxe;
        i_column_id    <= c.id;
        do @(posedge i_clk); while (o_in_stall);
        apply_chunk(c);
        if (c.op == OP_EMIT) emits_sent++;
        else folds_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_kind(input logic [2:0] k);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        kind_raw = k;
        clear_fold();
    endtask

    function automatic t_chunk emit_chunk();
        t_chunk c;
        c = '0;
        c.op = OP_EMIT;
        c.nc = 49'({$urandom, $urandom});
        c.nv = 48'({$urandom, $urandom});
        c.minv = {$urandom, $urandom};
        c.maxv = {$urandom, $urandom};
        c.minl = 8'($urandom); c.maxl = 8'($urandom);
        c.mine = 1'($urandom); c.maxe = 1'($urandom);
        c.id = 31'($urandom_range(1, 32'h7FFF_FFFF));
        return c;
    endfunction

    function automatic logic [63:0] rand_bound(input t_kind k);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = (k == K_I32 || k == K_F32) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
            3: v = (k == K_I32 || k == K_F32) ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
            default: ;
        endcase
        if (k == K_BYTES && $urandom_range(0, 1))
            for (int i = 0; i < 8; i++)
                v[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'h00 :
                              ($urandom_range(0, 1) ? 8'h61 : 8'hFF);
        if (k == K_BOOL && $urandom_range(0, 1)) v[7:0] = 8'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic void spoil_side(input t_kind k, inout logic [7:0] len,
                                       inout logic [63:0] v, inout logic exact);
        case ($urandom_range(0, 2))
            0: len = 8'($urandom_range(0, 255));
            1: exact = 0;
            default: begin
                if (k == K_F32) v[30:0] = {8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
                else if (k == K_F64) v[62:0] = {11'h7FF, 52'({$urandom, $urandom} | 64'd1)};
                else len = 0;
            end
        endcase
    endfunction

    function automatic t_chunk rand_fold(input bit noisy);
        t_chunk c;
        t_kind  k;
        k = eff_kind();
        c = '0;
        c.op = OP_FOLD;
        c.id = 31'($urandom);
        c.nv = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom}) :
                                             48'($urandom_range(0, 1000));
        case ($urandom_range(0, 11))
            0: c.nc = '1;
            1: c.nc = {1'b1, 16'($urandom), $urandom};
            2, 3: c.nc = {1'b0, c.nv};
            4: c.nc = {1'b0, 16'($urandom), $urandom};
            default: c.nc = 49'($urandom_range(0, 100));
        endcase
        c.minl = (k == K_BYTES || k == K_NONE) ? 8'($urandom_range(1, 8)) : {4'd0, width_of(k)};
        c.maxl = (k == K_BYTES || k == K_NONE) ? 8'($urandom_range(1, 8)) : {4'd0, width_of(k)};
        c.minv = rand_bound(k);
        c.maxv = rand_bound(k);
        c.mine = (k == K_BYTES) ? 1'b1 : 1'($urandom);
        c.maxe = (k == K_BYTES) ? 1'b1 : 1'($urandom);
        if (noisy && $urandom_range(0, 1)) spoil_side(k, c.minl, c.minv, c.mine);
        if (noisy && $urandom_range(0, 1)) spoil_side(k, c.maxl, c.maxv, c.maxe);
        return c;
    endfunction

    function automatic t_chunk fixed_chunk(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [7:0] len, input logic [48:0] nc);
        t_chunk c;
        c = '0;
        c.op = OP_FOLD;
        c.nc = nc; c.nv = 48'd50;
        c.minl = len; c.maxl = len;
        c.minv = lo; c.maxv = hi;
        c.mine = 1; c.maxe = 1;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_entry e, got;
        if (o_out_valid && !i_out_stall) begin
            got = {o_entry_valid, o_entry_id, o_null_total, o_has_lower, o_lower_len,
                   o_lower_value, o_has_upper, o_upper_len, o_upper_value};
            if (pending_entries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected entry %h", got);
            end else begin
                e = pending_entries.pop_front();
                entries_checked++;
                if (got.ev !== e.ev || got.id !== e.id || got.nt !== e.nt ||
                    got.hl !== e.hl || got.ll !== e.ll || got.lv !== e.lv ||
                    got.hu !== e.hu || got.ul !== e.ul || got.uv !== e.uv) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("entry mismatch id %0d", e.id);
                        $display("  exp valid=%b nulls=%h lo=%b/%0d/%h hi=%b/%0d/%h",
                                 e.ev, e.nt, e.hl, e.ll, e.lv, e.hu, e.ul, e.uv);
                        $display("  got valid=%b id=%0d nulls=%h lo=%b/%0d/%h hi=%b/%0d/%h",
                                 got.ev, got.id, got.nt, got.hl, got.ll, got.lv,
                                 got.hu, got.ul, got.uv);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_out_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  i_out_stall <= 1'b0;
                [70:96]: i_out_stall <= 1'b1;
                default: begin
                    rx_hold = $urandom_range(5, 30);
                    i_out_stall <= 1'b1;
                end
            endcase
        end
    end

    task automatic test_kind_none();
        send_chunk(fixed_chunk(64'h11, 64'h22, 8'd4, 49'd3));
        send_chunk(fixed_chunk(64'h11, 64'h22, 8'd1, '1));
        send_chunk(emit_chunk());
        send_chunk(emit_chunk());
    endtask

    task automatic test_extremes();
        write_kind(K_I32);
        send_chunk(fixed_chunk(64'h8000_0000, 64'h7FFF_FFFF, 8'd4, 49'd0));
        send_chunk(fixed_chunk(64'hFFFF_FFFF_0000_0000, 64'h1, 8'd4, 49'd7));
        send_chunk(emit_chunk());
        write_kind(K_I64);
        send_chunk(fixed_chunk(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'd8, 49'd1));
        send_chunk(fixed_chunk(64'h0, 64'h0, 8'd8, 49'd50));
        send_chunk(emit_chunk());
        write_kind(K_F32);
        send_chunk(fixed_chunk(64'h0, 64'h8000_0000, 8'd4, 49'd2));
        send_chunk(fixed_chunk(64'h8000_0000, 64'h0, 8'd4, 49'h1_0000_0000_0000));
        send_chunk(emit_chunk());
        write_kind(K_F64);
        send_chunk(fixed_chunk(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 8'd8, 49'd0));
        send_chunk(fixed_chunk(64'h7FF8_0000_0000_0000, 64'h0, 8'd8, 49'd0));
        send_chunk(emit_chunk());
        write_kind(K_BOOL);
        send_chunk(fixed_chunk(64'h1, 64'h0, 8'd1, 49'd0));
        send_chunk(fixed_chunk(64'h0, 64'hFF, 8'd1, 49'd0));
        send_chunk(emit_chunk());
        write_kind(K_BYTES);
        send_chunk(fixed_chunk(64'h6161, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2, 49'd0));
        send_chunk(fixed_chunk(64'h61, 64'h6161, 8'd1, 49'd0));
        send_chunk(fixed_chunk(64'h0, 64'h0, 8'd9, 49'd0));
        send_chunk(emit_chunk());
    endtask

    task automatic test_null_saturation();
        t_chunk c;
        write_kind(K_I32);
        tx_quiet = 1;
        repeat (258) begin
            c = fixed_chunk(64'h5, 64'h9, 8'd4, {1'b0, 48'hFFFF_FFFF_FFFF});
            c.nv = 48'd1;
            send_chunk(c);
        end
        send_chunk(emit_chunk());
        tx_quiet = 0;
    endtask

    task automatic test_random_kinds(input int count);
        logic [2:0] kinds[8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0};
        foreach (kinds[i]) begin
            write_kind(kinds[i]);
            rx_quiet = (i == 2);
            tx_quiet = (i == 2);
            repeat (count) begin
                if ($urandom_range(0, 7) == 0) send_chunk(emit_chunk());
                else send_chunk(rand_fold($urandom_range(0, 9) == 0));
            end
            send_chunk(emit_chunk());
        end
        rx_quiet = 0;
        tx_quiet = 0;
    endtask

    task automatic test_backpressure();
        write_kind(K_BYTES);
        rx_hold = 300;
        tx_quiet = 1;
        repeat (40) begin
            if ($urandom_range(0, 2) == 0) send_chunk(emit_chunk());
            else send_chunk(rand_fold(0));
        end
        tx_quiet = 0;
        drain();
        repeat (20) send_chunk(rand_fold(0));
        send_chunk(emit_chunk());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_out_stall    <= 1'b0;
        i_operation    <= 1'b0;
        i_null_count   <= '0;
        i_num_values   <= '0;
        i_min_len      <= '0;
        i_min_value    <= '0;
        i_max_len      <= '0;
        i_max_value    <= '0;
        i_min_is_exact <= 1'b0;
        i_max_is_exact <= 1'b0;
        i_column_id    <= 31'd1;
        kind_raw = 3'd0;
        clear_fold();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_kind_none();
        test_extremes();
        test_null_saturation();
        test_random_kinds(80);
        test_backpressure();
        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered all value kinds incl. reserved, saturation, unknown nulls, stalls.");
        $display("Sent %0d folds and %0d emits, checked %0d entries.",
                 folds_sent, emits_sent, entries_checked);
        if (mismatches == 0 && pending_entries.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
